[design/qla_pkg.sv]
// Shared constants, types and request/response structs of the Q-learning agent.
package qla_pkg;

  localparam int MaxStates  = 4096;
  localparam int MaxActions = 9;
  localparam int ValueBits  = 32;
  localparam int StateW     = $clog2(MaxStates);
  localparam int ColW       = $clog2(MaxActions);
  localparam int ActW       = 4;
  localparam int MaxJoints  = (MaxActions - 1) / 2;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 20;

  localparam logic [CfgIdxW-1:0] CfgLearnRate   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgDiscount    = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgMovePenalty = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgJointCount  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgAngleSteps  = 3'd4;

  localparam logic [16:0] RouletteScale = 17'd100000;
  localparam logic [16:0] UnitQ16       = 17'd65536;

  // shared divider: quotient known to fit DivQuoW bits
  localparam int DivNumW = 48;
  localparam int DivDenW = 35;
  localparam int DivQuoW = 17;

  typedef logic [ValueBits-1:0] value_t;
  typedef value_t [MaxActions-1:0] row_t;

  typedef struct packed {
    logic                 rd_en;
    logic [StateW-1:0]    rd_addr;
    logic                 wr_en;
    logic [StateW-1:0]    wr_addr;
    logic [ColW-1:0]      wr_col;
    value_t               wr_data;
  } tbl_req_t;

  typedef struct packed {
    logic               start;
    logic [DivNumW-1:0] num;
    logic [DivDenW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic               busy;
    logic [DivQuoW-1:0] quo;
    logic [DivDenW-1:0] rem;
  } div_rsp_t;

endpackage

[design/tabular_q_learning_agent.sv]
// Top level of the tabular Q-learning agent: item sequencer and update datapath.
//
// One word at a time. After reset the Q table (4096 rows of 9 values) is swept to zero,
// during which no input word is taken; configuration writes work throughout. An act
// word scans one table value per cycle over the A = 1 + 2 * joint_count actions of its
// row; roulette adds, for each action tried, a multiply and a division for the ratio.
// Moving a joint adds a power loop, two divisions for the digit and two small
// multiplies. An update word does the row max scan, a second row read and a five-step
// multiply/add chain before the table write. The divider is bit-serial and shared,
// and the table has a single row read port. The result word waits in an output
// register while the next input word is taken.
module tabular_q_learning_agent import qla_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // curiosity[30:0], random_draw[47:31], random_start[51:48], reward[83:52]
  input  logic [87:0]         s_axis_tdata,
  // kind[0], greedy[1]
  input  logic [1:0]          s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // chosen_action[3:0], next_state_index[15:4], moved_joint[17:16], rotation[19:18],
  // best_next_value[50:20], new_value[82:51], status[83]
  output logic [87:0]         m_axis_tdata
);

  typedef enum logic [4:0] {
    S_IDLE, S_LOAD, S_SCAN, S_RMUL, S_RDIV, S_RWAIT, S_NEXT, S_POW, S_D1, S_D1W,
    S_D2W, S_NW, S_MUL2, S_FIN, S_QREAD, S_QGET, S_GMUL, S_DIFF, S_HMUL, S_LMUL,
    S_SUM, S_OUT
  } state_e;

  state_e state_q;

  // configuration
  logic [16:0] lr_q, disc_q;
  logic [19:0] mp_q;
  logic [2:0]  jc_q;
  logic [4:0]  as_q;

  logic [StateW-1:0] cur_state_q, pend_state_q;
  logic [ActW-1:0]   pend_act_q;

  // item
  logic        kind_q, greedy_q;
  logic [30:0] curio_q;
  logic [16:0] draw_q;
  logic [3:0]  start_q;
  logic [31:0] reward_q;

  // working registers
  logic [ColW-1:0]   idx_q, best_q;
  value_t            bv_q, qv_q, newv_q;
  logic [34:0]       sum_q;
  logic [30:0]       max_q;
  logic [17:0]       cnt_q;
  logic [47:0]       prod_q;
  logic [ActW-1:0]   action_q;
  logic [14:0]       pw_q;
  logic [1:0]        pcnt_q;
  logic [StateW-1:0] t1_q, t2_q, nstate_q;
  logic [4:0]        old_q, nw_q;
  logic [31:0]       g_q;
  logic signed [35:0] d_q;
  logic signed [37:0] hp_q;
  logic [16:0]       lp_q;

  logic        m_valid_q;
  logic [87:0] m_data_q;

  // effective configuration
  logic [2:0]      jn;
  logic [4:0]      p_eff;
  logic [ActW-1:0] acts, last_idx;
  logic [16:0]     alpha, gamma;
  logic            status;

  always_comb begin
    jn       = (jc_q == 3'd0) ? 3'd1 : ((jc_q > 3'(MaxJoints)) ? 3'(MaxJoints) : jc_q);
    p_eff    = (as_q < 5'd2) ? 5'd2 : as_q;
    acts     = {jn, 1'b1};
    last_idx = acts - 1'b1;
    alpha    = (lr_q > UnitQ16) ? UnitQ16 : lr_q;
    gamma    = (disc_q > UnitQ16) ? UnitQ16 : disc_q;
    // p^jn > 4096, p below 32
    status   = ((jn == 3'd3) && (p_eff > 5'd16)) || ((jn == 3'd4) && (p_eff > 5'd8));
  end

  function automatic logic [ColW-1:0] mod_acts(input logic [3:0] v, input logic [3:0] n);
    logic [3:0] r;
    r = v;
    for (int k = 0; k < 5; k++) begin
      if (r >= n) r = r - n;
    end
    return ColW'(r);
  endfunction

  function automatic logic [30:0] weight(input value_t q, input logic [30:0] c);
    return ($signed(q) <= 0) ? c : q[30:0];
  endfunction

  function automatic logic [1:0] joint_of(input logic [ActW-1:0] a);
    logic [ActW-1:0] t;
    t = ((a + 1'b1) >> 1) - 1'b1;
    return (a == '0) ? 2'd0 : t[1:0];
  endfunction

  function automatic logic [1:0] rot_of(input logic [ActW-1:0] a);
    return (a == '0) ? 2'b00 : (a[0] ? 2'b01 : 2'b11);
  endfunction

  function automatic value_t sat32(input logic signed [39:0] x);
    if (x > 40'sh007FFFFFFF) return 32'h7FFFFFFF;
    if (x < -40'sh0080000000) return 32'h80000000;
    return x[31:0];
  endfunction

  // sub-blocks
  tbl_req_t tbl_req;
  row_t     row;
  logic     tbl_busy;
  div_req_t div_req;
  div_rsp_t div_rsp;

  qla_table u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (tbl_req),
    .rd_row_o(row),
    .busy_o  (tbl_busy)
  );

  qla_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  logic              accept;
  value_t            row_i;
  logic signed [39:0] upd_sum;
  value_t            upd_val;
  logic [17:0]       cnt_next;

  assign s_axis_tready = (state_q == S_IDLE) && !tbl_busy;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  always_comb begin
    row_i    = row[idx_q];
    cnt_next = cnt_q + 18'(div_rsp.quo);
    upd_sum  = 40'(signed'(qv_q)) + 40'(hp_q) + $signed({23'd0, lp_q});
    upd_val  = sat32(upd_sum);

    tbl_req.rd_en   = accept || (state_q == S_QREAD);
    tbl_req.rd_addr = (accept && s_axis_tuser[0]) ? pend_state_q : cur_state_q;
    tbl_req.wr_en   = (state_q == S_SUM);
    tbl_req.wr_addr = cur_state_q;
    tbl_req.wr_col  = ColW'(pend_act_q);
    tbl_req.wr_data = upd_val;

    div_req.start = 1'b0;
    div_req.num   = {28'd0, cur_state_q, 8'd0} >> 8;
    div_req.den   = {20'd0, pw_q};
    case (state_q)
      S_RDIV: begin
        div_req.start = 1'b1;
        div_req.num   = prod_q;
        div_req.den   = sum_q;
      end
      S_D1: begin
        div_req.start = 1'b1;
      end
      S_D1W: begin
        div_req.start = div_rsp.done;
        div_req.num   = DivNumW'(div_rsp.quo);
        div_req.den   = DivDenW'(p_eff);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q   <= 17'd6554;
      disc_q <= 17'd58982;
      mp_q   <= '0;
      jc_q   <= 3'd2;
      as_q   <= 5'd8;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgLearnRate:   lr_q   <= cfg_data_i[16:0];
        CfgDiscount:    disc_q <= cfg_data_i[16:0];
        CfgMovePenalty: mp_q   <= cfg_data_i;
        CfgJointCount:  jc_q   <= cfg_data_i[2:0];
        CfgAngleSteps:  as_q   <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cur_state_q  <= '0;
      pend_state_q <= '0;
      pend_act_q   <= '0;
      kind_q       <= 1'b0;
      greedy_q     <= 1'b0;
      curio_q      <= '0;
      draw_q       <= '0;
      start_q      <= '0;
      reward_q     <= '0;
      idx_q        <= '0;
      best_q       <= '0;
      bv_q         <= '0;
      qv_q         <= '0;
      newv_q       <= '0;
      sum_q        <= '0;
      max_q        <= '0;
      cnt_q        <= '0;
      prod_q       <= '0;
      action_q     <= '0;
      pw_q         <= '0;
      pcnt_q       <= '0;
      t1_q         <= '0;
      t2_q         <= '0;
      nstate_q     <= '0;
      old_q        <= '0;
      nw_q         <= '0;
      g_q          <= '0;
      d_q          <= '0;
      hp_q         <= '0;
      lp_q         <= '0;
      m_valid_q    <= 1'b0;
      m_data_q     <= '0;
    end else begin
      // S_OUT reloads the output register itself
      if (m_valid_q && m_axis_tready && (state_q != S_OUT)) m_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            kind_q   <= s_axis_tuser[0];
            greedy_q <= s_axis_tuser[1];
            curio_q  <= s_axis_tdata[30:0];
            draw_q   <= s_axis_tdata[47:31];
            start_q  <= s_axis_tdata[51:48];
            reward_q <= s_axis_tdata[83:52];
            state_q  <= S_LOAD;
          end
        end
        S_LOAD: begin
          idx_q    <= '0;
          sum_q    <= '0;
          max_q    <= '0;
          cnt_q    <= '0;
          best_q   <= mod_acts(start_q, acts);
          bv_q     <= row[mod_acts(start_q, acts)];
          action_q <= kind_q ? pend_act_q : '0;
          nstate_q <= pend_state_q;
          state_q  <= S_SCAN;
        end
        S_SCAN: begin
          if (kind_q) begin
            if ($signed(row_i) > $signed({1'b0, max_q})) max_q <= row_i[30:0];
          end else if (greedy_q) begin
            if ($signed(row_i) > $signed(bv_q)) begin
              bv_q   <= row_i;
              best_q <= idx_q;
            end
          end else begin
            sum_q <= sum_q + 35'(weight(row_i, curio_q));
          end
          if (idx_q == ColW'(last_idx)) begin
            if (kind_q) begin
              state_q <= S_QREAD;
            end else if (greedy_q) begin
              action_q <= ActW'(($signed(row_i) > $signed(bv_q)) ? idx_q : best_q);
              state_q  <= S_NEXT;
            end else if ((sum_q + 35'(weight(row_i, curio_q))) == '0) begin
              state_q <= S_NEXT;
            end else begin
              idx_q   <= '0;
              state_q <= S_RMUL;
            end
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_RMUL: begin
          prod_q  <= 48'(RouletteScale) * 48'(weight(row_i, curio_q));
          state_q <= S_RDIV;
        end
        S_RDIV: state_q <= S_RWAIT;
        S_RWAIT: begin
          if (div_rsp.done) begin
            cnt_q <= cnt_next;
            if ({1'b0, draw_q} < cnt_next) begin
              action_q <= ActW'(idx_q);
              state_q  <= S_NEXT;
            end else if (idx_q == ColW'(last_idx)) begin
              state_q <= S_NEXT;
            end else begin
              idx_q   <= idx_q + 1'b1;
              state_q <= S_RMUL;
            end
          end
        end
        S_NEXT: begin
          if (action_q == '0) begin
            nstate_q     <= cur_state_q;
            pend_state_q <= cur_state_q;
            pend_act_q   <= '0;
            state_q      <= S_OUT;
          end else begin
            pw_q    <= 15'd1;
            pcnt_q  <= '0;
            state_q <= S_POW;
          end
        end
        S_POW: begin
          if (pcnt_q == joint_of(action_q)) begin
            state_q <= S_D1;
          end else begin
            pw_q   <= 15'(pw_q * p_eff);
            pcnt_q <= pcnt_q + 1'b1;
          end
        end
        S_D1: state_q <= S_D1W;
        S_D1W: begin
          if (div_rsp.done) begin
            state_q <= S_D2W;
          end
        end
        S_D2W: begin
          if (div_rsp.done) begin
            old_q   <= div_rsp.rem[4:0];
            state_q <= S_NW;
          end
        end
        S_NW: begin
          // digit turned by one with wrap
          if (action_q[0]) begin
            nw_q <= (old_q + 1'b1 == p_eff) ? 5'd0 : old_q + 1'b1;
          end else begin
            nw_q <= (old_q == 5'd0) ? p_eff - 1'b1 : old_q - 1'b1;
          end
          t1_q    <= StateW'(old_q * pw_q);
          state_q <= S_MUL2;
        end
        S_MUL2: begin
          t2_q    <= StateW'(nw_q * pw_q);
          state_q <= S_FIN;
        end
        S_FIN: begin
          nstate_q     <= cur_state_q - t1_q + t2_q;
          pend_state_q <= cur_state_q - t1_q + t2_q;
          pend_act_q   <= action_q;
          state_q      <= S_OUT;
        end
        S_QREAD: state_q <= S_QGET;
        S_QGET: begin
          qv_q    <= row[ColW'(pend_act_q)];
          state_q <= S_GMUL;
        end
        S_GMUL: begin
          g_q     <= 32'((48'(gamma) * 48'(max_q)) >> 16);
          state_q <= S_DIFF;
        end
        S_DIFF: begin
          d_q <= 36'(signed'(reward_q)) - $signed({16'd0, mp_q})
               + $signed({4'd0, g_q}) - 36'(signed'(qv_q));
          state_q <= S_HMUL;
        end
        S_HMUL: begin
          hp_q    <= 38'($signed(d_q[35:16]) * $signed({1'b0, alpha}));
          state_q <= S_LMUL;
        end
        S_LMUL: begin
          lp_q    <= 17'((33'(d_q[15:0]) * 33'(alpha)) >> 16);
          state_q <= S_SUM;
        end
        S_SUM: begin
          newv_q      <= upd_val;
          cur_state_q <= pend_state_q;
          state_q     <= S_OUT;
        end
        S_OUT: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            m_data_q  <= {4'd0, status,
                          kind_q ? newv_q : 32'd0,
                          kind_q ? max_q : 31'd0,
                          rot_of(action_q), joint_of(action_q),
                          nstate_q, action_q};
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> state_q != S_IDLE)
    else $error("sequencer stayed idle after taking a word");

  a_no_write_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_req.wr_en |-> !tbl_busy)
    else $error("table write during clearing sweep");

  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_RWAIT || state_q == S_D1W || state_q == S_D2W))
    else $error("divider finished with no one waiting");

  a_pend_act_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_act_q < ActW'(MaxActions))
    else $error("pending action outside table row");

endmodule

[design/qla_table.sv]
// Q table memory: one row of action values per state, cleared by a sweep after reset.
module qla_table import qla_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  tbl_req_t req_i,
  output row_t     rd_row_o,
  output logic     busy_o
);

  row_t              mem [MaxStates];
  row_t              rd_q;
  logic              clr_busy_q;
  logic [StateW-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == StateW'(MaxStates - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem[clr_addr_q] <= '0;
    end else if (req_i.wr_en) begin
      mem[req_i.wr_addr][req_i.wr_col] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_q <= mem[req_i.rd_addr];
    end
  end

  assign rd_row_o = rd_q;
  assign busy_o   = clr_busy_q;

endmodule

[design/qla_div.sv]
// Restoring divider, one quotient bit per cycle.
module qla_div import qla_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int CntW = $clog2(DivQuoW + 1);

  logic               busy_q, done_q;
  logic [CntW-1:0]    cnt_q;
  logic [DivDenW-1:0] rem_q, den_q;
  logic [DivQuoW-1:0] low_q, quo_q;
  logic [DivDenW:0]   trial;
  logic               qbit;
  logic [DivDenW-1:0] rem_d;

  always_comb begin
    trial = {rem_q, low_q[DivQuoW-1]};
    qbit  = trial >= {1'b0, den_q};
    rem_d = qbit ? DivDenW'(trial - {1'b0, den_q}) : trial[DivDenW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      den_q  <= '0;
      low_q  <= '0;
      quo_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CntW'(DivQuoW);
      // upper bits are below the divisor by precondition
      rem_q  <= DivDenW'(req_i.num >> DivQuoW);
      low_q  <= req_i.num[DivQuoW-1:0];
      den_q  <= req_i.den;
      quo_q  <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      low_q <= {low_q[DivQuoW-2:0], 1'b0};
      quo_q <= {quo_q[DivQuoW-2:0], qbit};
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.busy = busy_q;
  assign rsp_o.quo  = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule
